/* hdl/fsf_pkg.sv */
// Shared constants, types and the exponent table for the Fermi switching function.
package fsf_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int EXP_TABLE_SIZE  = EXP_TABLE_DEPTH + 1;
    localparam int EXP_ADDR_W      = $clog2(EXP_TABLE_SIZE);
    localparam int EXP_W           = 31;

    localparam longint unsigned Q30_ONE   = 64'd1073741824;
    localparam longint unsigned LOG2E_Q30 = 64'd1549082005;
    localparam longint unsigned LN2_Q30   = 64'd744261118;

    localparam logic [39:0] SLOPE_POS_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] SLOPE_NEG_MIN = 40'h80_0000_0000;

    localparam logic [7:0] REG_CUTOFF    = 8'd0;
    localparam logic [7:0] REG_STEEPNESS = 8'd1;
    localparam logic [7:0] REG_CLAMP_EN  = 8'd2;
    localparam logic [7:0] REG_CLAMP_MAX = 8'd3;

    typedef logic [EXP_W-1:0] exp_tab_t [EXP_TABLE_SIZE];

    // shift-subtract quotient for table generation
    function automatic longint unsigned udiv64(input longint unsigned a,
                                               input longint unsigned b);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[62:0], a[j]};
            if (rem >= b) begin
                rem = rem - b;
                quo[j] = 1'b1;
            end
        end
        return quo;
    endfunction

    // 2^(-i/depth) in Q30 by a truncated Taylor series
    function automatic logic [EXP_W-1:0] exp_entry(input longint unsigned i);
        longint unsigned x;
        longint unsigned term;
        longint sum;
        x = (i * LN2_Q30 + EXP_TABLE_DEPTH / 2) / EXP_TABLE_DEPTH;
        term = Q30_ONE;
        sum = longint'(Q30_ONE);
        for (int n = 1; n <= 24; n++) begin
            term = udiv64((term * x + (Q30_ONE >> 1)) >> 30, longint'(n));
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
        return EXP_W'(sum);
    endfunction

    function automatic exp_tab_t build_exp_table();
        exp_tab_t tab;
        for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
            tab[i] = exp_entry(longint'(i));
        end
        return tab;
    endfunction

endpackage

/* hdl/fsf_rom.sv */
// Exponent table with registered read.
module fsf_rom (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [fsf_pkg::EXP_ADDR_W-1:0] addr,
    output logic [fsf_pkg::EXP_W-1:0]      data
);
    import fsf_pkg::*;

    localparam exp_tab_t EXP_TABLE = build_exp_table();

    logic [EXP_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= EXP_TABLE[addr];
        end
    end

    assign data = data_reg;
endmodule

/* hdl/fsf_div_cell.sv */
// One restoring division cell: decides one quotient bit and passes the word on.
module fsf_div_cell #(
    parameter int NW    = 47,
    parameter int DW    = 32,
    parameter int QW    = 17,
    parameter int SHIFT = 0,
    parameter int SW    = 1
) (
    input  logic          aclk,
    input  logic          ce,
    input  logic [NW-1:0] rem_in,
    input  logic [DW-1:0] den_in,
    input  logic [QW-1:0] quo_in,
    input  logic [SW-1:0] side_in,
    output logic [NW-1:0] rem_out,
    output logic [DW-1:0] den_out,
    output logic [QW-1:0] quo_out,
    output logic [SW-1:0] side_out
);
    localparam int W = (NW > DW + SHIFT) ? NW : DW + SHIFT;

    logic [W-1:0]  rem_ext;
    logic [W-1:0]  den_sh;
    logic          ge;
    logic [NW-1:0] rem_next;
    logic [QW-1:0] quo_next;
    logic [NW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quo_reg;
    logic [SW-1:0] side_reg;

    always_comb begin
        rem_ext  = W'(rem_in);
        den_sh   = W'(den_in) << SHIFT;
        ge       = rem_ext >= den_sh;
        rem_next = ge ? NW'(rem_ext - den_sh) : rem_in;
        quo_next = quo_in;
        quo_next[SHIFT] = ge;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;
endmodule

/* hdl/fsf_divider.sv */
// Row of division cells, one quotient bit per cell, most significant first.
module fsf_divider #(
    parameter int NW = 47,
    parameter int DW = 32,
    parameter int QW = 17,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          ce,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);
    logic [NW-1:0] rem_c  [QW+1];
    logic [DW-1:0] den_c  [QW+1];
    logic [QW-1:0] quo_c  [QW+1];
    logic [SW-1:0] side_c [QW+1];

    assign rem_c[0]  = num;
    assign den_c[0]  = den;
    assign quo_c[0]  = '0;
    assign side_c[0] = side_in;

    for (genvar i = 0; i < QW; i++) begin : g_cell
        fsf_div_cell #(
            .NW(NW), .DW(DW), .QW(QW), .SHIFT(QW - 1 - i), .SW(SW)
        ) u_cell (
            .aclk    (aclk),
            .ce      (ce),
            .rem_in  (rem_c[i]),
            .den_in  (den_c[i]),
            .quo_in  (quo_c[i]),
            .side_in (side_c[i]),
            .rem_out (rem_c[i+1]),
            .den_out (den_c[i+1]),
            .quo_out (quo_c[i+1]),
            .side_out(side_c[i+1])
        );
    end

    assign quo      = quo_c[QW];
    assign side_out = side_c[QW];
endmodule

/* hdl/fermi_switching_function.sv */
// Fermi switching function 1/(1+e^r) and its slope over distance, fully pipelined.
// Throughput: one word per cycle while the output is not stalled;
// the two divider rows of 17 and 40 cells set the depth.
// The whole pipeline advances whenever the output register is empty or being taken.
// Synchronous active-low reset clears valid bits and restores register defaults.
module fermi_switching_function (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] distance
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [16:0] switch_value, [56:17] slope_over_distance, zero pad
    output logic        m_tuser,   // [0] slope_saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import fsf_pkg::*;

    localparam int DIV1_QW = 17;
    localparam int DIV2_QW = 40;
    localparam int LAT     = 5 + DIV1_QW + 2 + DIV2_QW + 1;

    localparam logic [21:0] M_MAX = 22'(40 << FRAC_BITS);

    logic [23:0]        cutoff_reg;
    logic signed [23:0] steep_reg;
    logic               clamp_en_reg;
    logic signed [23:0] clamp_max_reg;

    logic               ce;
    logic [LAT-1:0]     vld_reg;

    assign cfg_ready = 1'b1;
    assign ce        = !vld_reg[LAT-1] || m_tready;
    assign s_tready  = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg    <= '0;
            steep_reg     <= 24'sd65536;
            clamp_en_reg  <= 1'b1;
            clamp_max_reg <= 24'sd6553600;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CUTOFF:    cutoff_reg    <= cfg_data;
                REG_STEEPNESS: steep_reg     <= $signed(cfg_data);
                REG_CLAMP_EN:  clamp_en_reg  <= cfg_data[0];
                REG_CLAMP_MAX: clamp_max_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // stage 1: r before rounding
    logic signed [24:0] diff;
    logic signed [48:0] prod_reg;
    logic [23:0]        d1_reg;
    logic signed [23:0] st1_reg;

    assign diff = $signed({1'b0, s_tdata}) - $signed({1'b0, cutoff_reg});

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= 49'(steep_reg) * 49'(diff);
            d1_reg   <= s_tdata;
            st1_reg  <= steep_reg;
        end
    end

    // stage 2: round, clamp, magnitude
    logic [48:0]        pm;
    logic [33:0]        rm;
    logic signed [34:0] r_raw;
    logic signed [34:0] r_cl;
    logic signed [34:0] cmax_ext;
    logic [34:0]        r_mag;
    logic [21:0]        m2_reg;
    logic               rneg2_reg;
    logic [23:0]        d2_reg;
    logic signed [23:0] st2_reg;

    always_comb begin
        pm       = prod_reg[48] ? 49'(-prod_reg) : 49'(prod_reg);
        rm       = 34'((pm + 49'd32768) >> FRAC_BITS);
        r_raw    = prod_reg[48] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
        cmax_ext = 35'(clamp_max_reg);
        r_cl     = (clamp_en_reg && r_raw >= cmax_ext) ? cmax_ext : r_raw;
        r_mag    = r_cl[34] ? 35'(-r_cl) : 35'(r_cl);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m2_reg    <= (r_mag > 35'(M_MAX)) ? M_MAX : r_mag[21:0];
            rneg2_reg <= r_cl[34];
            d2_reg    <= d1_reg;
            st2_reg   <= st1_reg;
        end
    end

    // stage 3: |r| * log2(e)
    logic [52:0]        t_full;
    logic [21:0]        t3_reg;
    logic               rneg3_reg;
    logic [23:0]        d3_reg;
    logic signed [23:0] st3_reg;

    assign t_full = 53'(m2_reg) * 53'(LOG2E_Q30) + 53'(Q30_ONE >> 1);

    always_ff @(posedge aclk) begin
        if (ce) begin
            t3_reg    <= t_full[51:30];
            rneg3_reg <= rneg2_reg;
            d3_reg    <= d2_reg;
            st3_reg   <= st2_reg;
        end
    end

    // stage 4: table lookup
    logic [16:0]           f_rnd;
    logic [EXP_ADDR_W-1:0] idx;
    logic [EXP_W-1:0]      tab_q;
    logic [5:0]            k4_reg;
    logic                  rneg4_reg;
    logic [23:0]           d4_reg;
    logic signed [23:0]    st4_reg;

    assign f_rnd = {1'b0, t3_reg[15:0]} + 17'd32;
    assign idx   = EXP_ADDR_W'(f_rnd[16:6]);

    fsf_rom u_rom (
        .aclk(aclk),
        .en  (ce),
        .addr(idx),
        .data(tab_q)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            k4_reg    <= t3_reg[21:16];
            rneg4_reg <= rneg3_reg;
            d4_reg    <= d3_reg;
            st4_reg   <= st3_reg;
        end
    end

    // stage 5: operands of s
    logic [EXP_W-1:0]   e_val;
    logic [31:0]        den1;
    logic [46:0]        num1_reg;
    logic [31:0]        den1_reg;
    logic [47:0]        side1_reg;

    always_comb begin
        e_val = (k4_reg >= 6'd31) ? '0 : (tab_q >> k4_reg);
        den1  = 32'(Q30_ONE) + 32'(e_val);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            num1_reg  <= (rneg4_reg ? 47'(Q30_ONE << FRAC_BITS) : {e_val, 16'b0})
                         + 47'(den1 >> 1);
            den1_reg  <= den1;
            side1_reg <= {d4_reg, st4_reg};
        end
    end

    logic [DIV1_QW-1:0] s_quo;
    logic [47:0]        side1_out;

    fsf_divider #(.NW(47), .DW(32), .QW(DIV1_QW), .SW(48)) u_div_s (
        .aclk    (aclk),
        .ce      (ce),
        .num     (num1_reg),
        .den     (den1_reg),
        .side_in (side1_reg),
        .quo     (s_quo),
        .side_out(side1_out)
    );

    // stage 6: u = s*(1-s)
    logic [16:0]        s_cl;
    logic [33:0]        su;
    logic [14:0]        u6_reg;
    logic [16:0]        s6_reg;
    logic [23:0]        d6_reg;
    logic signed [23:0] st6_reg;

    always_comb begin
        s_cl = (s_quo > 17'd65536) ? 17'd65536 : s_quo;
        su   = 34'(s_cl) * 34'(17'd65536 - s_cl) + 34'd32768;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            u6_reg  <= su[30:16];
            s6_reg  <= s_cl;
            d6_reg  <= side1_out[47:24];
            st6_reg <= $signed(side1_out[23:0]);
        end
    end

    // stage 7: |lambda| * u and divider operands
    logic [23:0]        lm;
    logic [38:0]        lnum;
    logic [39:0]        num2_reg;
    logic [23:0]        den2_reg;
    logic [19:0]        side2_reg;

    always_comb begin
        lm   = st6_reg[23] ? 24'(-st6_reg) : 24'(st6_reg);
        lnum = 39'(lm) * 39'(u6_reg);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            num2_reg  <= 40'(lnum) + 40'(d6_reg >> 1);
            den2_reg  <= (d6_reg == '0) ? 24'd1 : d6_reg;
            side2_reg <= {s6_reg, d6_reg == '0, lnum == '0,
                          !st6_reg[23] && st6_reg != '0};
        end
    end

    logic [DIV2_QW-1:0] q_quo;
    logic [19:0]        side2_out;

    fsf_divider #(.NW(40), .DW(24), .QW(DIV2_QW), .SW(20)) u_div_q (
        .aclk    (aclk),
        .ce      (ce),
        .num     (num2_reg),
        .den     (den2_reg),
        .side_in (side2_reg),
        .quo     (q_quo),
        .side_out(side2_out)
    );

    // output register: sign and saturation
    logic        dz;
    logic        nz;
    logic        ng;
    logic [39:0] slope_next;
    logic        sat_next;
    logic [16:0] sw_reg;
    logic [39:0] slope_reg;
    logic        sat_reg;

    always_comb begin
        dz = side2_out[2];
        nz = side2_out[1];
        ng = side2_out[0];
        sat_next   = 1'b0;
        slope_next = q_quo;
        if (dz) begin
            sat_next   = 1'b1;
            slope_next = nz ? '0 : (ng ? SLOPE_NEG_MIN : SLOPE_POS_MAX);
        end else if (ng) begin
            if (q_quo > SLOPE_NEG_MIN) begin
                sat_next   = 1'b1;
                slope_next = SLOPE_NEG_MIN;
            end else begin
                slope_next = 40'(-q_quo);
            end
        end else if (q_quo > SLOPE_POS_MAX) begin
            sat_next   = 1'b1;
            slope_next = SLOPE_POS_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sw_reg    <= side2_out[19:3];
            slope_reg <= slope_next;
            sat_reg   <= sat_next;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {7'b0, slope_reg, sw_reg};
    assign m_tuser  = sat_reg;

    a_sw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[16:0] <= 17'd65536)
        else $error("switch value above one");

    a_pipe_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        ce |=> m_tvalid == $past(vld_reg[LAT-2]))
        else $error("output valid out of step with pipeline");

    a_zero_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (ce && vld_reg[LAT-2] && dz) |=> m_tuser)
        else $error("zero distance without saturation flag");
endmodule
